// ===== hw/rtl/mrw_pkg.sv =====
// Package for the Miller-Rabin witness round unit: widths, sequencer codes,
// channel word types and the front-to-back job word type. No dependencies.
`timescale 1ns / 1ps
package mrw_pkg;
  localparam int NUM_WIDTH = 64;
  localparam int FIELD_WIDTH = 64;
  localparam int SHIFT_WIDTH = $clog2(NUM_WIDTH + 1);
  localparam int BIT_IDX_WIDTH = $clog2(NUM_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_WIDTH = $clog2(QUEUE_DEPTH);

  typedef logic [NUM_WIDTH-1:0] num_t;

  // input channel word
  typedef struct packed {
    logic [FIELD_WIDTH-1:0] candidate;
    logic [FIELD_WIDTH-1:0] witness_base;
  } in_word_t;

  // result channel word
  typedef struct packed {
    logic probably_prime;
  } out_word_t;

  // job handed from the front classifier to the back engine
  typedef struct packed {
    logic                   trivial;      // verdict already known
    logic                   verdict;      // verdict when trivial
    num_t                   modulus;      // odd candidate n
    num_t                   base;         // raw base, still to be reduced
    num_t                   exp_d;        // odd part d of n-1
    logic [SHIFT_WIDTH-1:0] shift_s;      // s with n-1 = d * 2^s
  } job_t;

  // back engine states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_POW    = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // modular multiplier use
  localparam logic [1:0] MUL_POW_R = 2'd0;
  localparam logic [1:0] MUL_POW_B = 2'd1;
  localparam logic [1:0] MUL_SQ    = 2'd2;
endpackage

// ===== hw/rtl/mrw_if.sv =====
// Valid/ready channel interface for words of any payload type.
// Depends on nothing; payload type is a type parameter.
`timescale 1ns / 1ps
interface mrw_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mrw_front.sv =====
// Front part: accepts a candidate/base word, classifies it and derives d and s.
// Depends on mrw_pkg. One word per item in a cycle-by-cycle trailing-zero strip.
`timescale 1ns / 1ps
module mrw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mrw_pkg::FIELD_WIDTH-1:0] in_candidate,
  input  logic [mrw_pkg::FIELD_WIDTH-1:0] in_witness_base,
  output logic                           job_valid,
  input  logic                           job_ready,
  output mrw_pkg::job_t                  job_data
);
  logic                busy_r, busy_nxt;
  mrw_pkg::job_t       job_r, job_nxt;
  mrw_pkg::num_t       n_w;

  assign n_w = in_candidate[mrw_pkg::NUM_WIDTH-1:0];
  assign in_ready = !busy_r;
  // done when trivial or d is odd
  assign job_valid = busy_r && (job_r.trivial || job_r.exp_d[0]);
  assign job_data = job_r;

  always_comb begin
    busy_nxt = busy_r;
    job_nxt = job_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        job_nxt.modulus = n_w;
        job_nxt.base = in_witness_base[mrw_pkg::NUM_WIDTH-1:0];
        job_nxt.exp_d = n_w - mrw_pkg::NUM_WIDTH'(1);
        job_nxt.shift_s = '0;
        job_nxt.trivial = 1'b0;
        job_nxt.verdict = 1'b0;
        if (n_w < mrw_pkg::NUM_WIDTH'(2)) begin
          job_nxt.trivial = 1'b1;
        end else if (n_w < mrw_pkg::NUM_WIDTH'(4)) begin
          job_nxt.trivial = 1'b1;
          job_nxt.verdict = 1'b1;
        end else if (!n_w[0]) begin
          job_nxt.trivial = 1'b1;
        end
      end
    end else if (job_valid) begin
      if (job_ready) busy_nxt = 1'b0;
    end else begin
      // strip one trailing zero of d
      job_nxt.exp_d = job_r.exp_d >> 1;
      job_nxt.shift_s = job_r.shift_s + mrw_pkg::SHIFT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
    job_r <= job_nxt;
  end
endmodule

// ===== hw/rtl/mrw_queue.sv =====
// Short job queue between the front and the back parts.
// Depends on mrw_pkg; flop-based ring of QUEUE_DEPTH entries.
`timescale 1ns / 1ps
module mrw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  mrw_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output mrw_pkg::job_t rd_data
);
  localparam int CW = mrw_pkg::QUEUE_IDX_WIDTH + 1;

  mrw_pkg::job_t                        mem_r [mrw_pkg::QUEUE_DEPTH];
  logic [mrw_pkg::QUEUE_IDX_WIDTH-1:0]  wp_r, rp_r;
  logic [mrw_pkg::QUEUE_IDX_WIDTH:0]    cnt_r;
  logic                                 push, pop;

  assign wr_ready = cnt_r != CW'(mrw_pkg::QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (push ? CW'(1) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== hw/rtl/mrw_back.sv =====
// Back part: base reduction, square-and-multiply and the squaring chain,
// built on one bit-serial modular multiplier. Depends on mrw_pkg.
`timescale 1ns / 1ps
module mrw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  mrw_pkg::job_t job_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_probably_prime
);
  localparam int NW = mrw_pkg::NUM_WIDTH;
  localparam int BW = mrw_pkg::BIT_IDX_WIDTH;

  logic [2:0]                       st_r, st_nxt;
  mrw_pkg::num_t                    n_r, n_nxt, b_r, b_nxt, e_r, e_nxt;
  mrw_pkg::num_t                    x_r, x_nxt, acc_r, acc_nxt, ma_r, ma_nxt, mb_r, mb_nxt;
  logic [mrw_pkg::SHIFT_WIDTH-1:0]  s_r, s_nxt;
  logic [BW-1:0]                    bit_r, bit_nxt;
  logic [1:0]                       use_r, use_nxt;
  logic                             pass_r, pass_nxt, res_r, res_nxt;
  logic                             ov_r, ov_nxt;
  logic [NW:0]                      dbl, add;
  mrw_pkg::num_t                    dbl_m, step, nm1;

  assign job_ready = st_r == mrw_pkg::ST_IDLE && !ov_r;
  assign out_valid = ov_r;
  assign out_probably_prime = res_r;
  assign nm1 = n_r - NW'(1);

  // one doubling and one conditional add per cycle
  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_m = (dbl >= {1'b0, n_r}) ? NW'(dbl - {1'b0, n_r}) : dbl[NW-1:0];
    add = {1'b0, dbl_m} + {1'b0, ma_r};
    step = mb_r[bit_r] ? ((add >= {1'b0, n_r}) ? NW'(add - {1'b0, n_r}) : add[NW-1:0])
                       : dbl_m;
  end

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; b_nxt = b_r; e_nxt = e_r; x_nxt = x_r;
    acc_nxt = acc_r; ma_nxt = ma_r; mb_nxt = mb_r; s_nxt = s_r; bit_nxt = bit_r;
    use_nxt = use_r; pass_nxt = pass_r; res_nxt = res_r; ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      mrw_pkg::ST_IDLE: begin
        if (job_valid && !ov_r) begin
          if (job_data.trivial) begin
            res_nxt = job_data.verdict;
            ov_nxt = 1'b1;
          end else begin
            n_nxt = job_data.modulus;
            b_nxt = job_data.base;
            e_nxt = job_data.exp_d;
            s_nxt = job_data.shift_s;
            x_nxt = NW'(1);
            acc_nxt = '0;
            bit_nxt = BW'(NW-1);
            st_nxt = mrw_pkg::ST_REDUCE;
          end
        end
      end
      mrw_pkg::ST_REDUCE: begin
        // base mod n by shift-subtract: acc = (acc*2 + base bit) mod n
        acc_nxt = (({acc_r, b_r[bit_r]}) >= {1'b0, n_r})
                  ? NW'({acc_r, b_r[bit_r]} - {1'b0, n_r}) : NW'({acc_r, b_r[bit_r]});
        if (bit_r == '0) begin
          b_nxt = acc_nxt;
          st_nxt = mrw_pkg::ST_POW;
        end else bit_nxt = bit_r - BW'(1);
      end
      mrw_pkg::ST_POW: begin
        if (e_r == '0) begin
          pass_nxt = x_r == NW'(1) || x_r == nm1;
          st_nxt = mrw_pkg::ST_SQUARE;
        end else begin
          ma_nxt = e_r[0] ? x_r : b_r;
          mb_nxt = b_r;
          use_nxt = e_r[0] ? mrw_pkg::MUL_POW_R : mrw_pkg::MUL_POW_B;
          acc_nxt = '0;
          bit_nxt = BW'(NW-1);
          st_nxt = mrw_pkg::ST_MUL;
        end
      end
      mrw_pkg::ST_SQUARE: begin
        if (s_r <= mrw_pkg::SHIFT_WIDTH'(1)) begin
          res_nxt = pass_r;
          ov_nxt = 1'b1;
          st_nxt = mrw_pkg::ST_DONE;
        end else begin
          s_nxt = s_r - mrw_pkg::SHIFT_WIDTH'(1);
          ma_nxt = x_r;
          mb_nxt = x_r;
          use_nxt = mrw_pkg::MUL_SQ;
          acc_nxt = '0;
          bit_nxt = BW'(NW-1);
          st_nxt = mrw_pkg::ST_MUL;
        end
      end
      mrw_pkg::ST_MUL: begin
        acc_nxt = step;
        if (bit_r == '0) begin
          case (use_r)
            mrw_pkg::MUL_POW_R: begin
              x_nxt = step;
              use_nxt = mrw_pkg::MUL_POW_B;
              ma_nxt = b_r;
              acc_nxt = '0;
              bit_nxt = BW'(NW-1);
            end
            mrw_pkg::MUL_POW_B: begin
              b_nxt = step;
              e_nxt = e_r >> 1;
              st_nxt = mrw_pkg::ST_POW;
            end
            mrw_pkg::MUL_SQ: begin
              x_nxt = step;
              if (step == nm1) pass_nxt = 1'b1;
              st_nxt = mrw_pkg::ST_SQUARE;
            end
            default: st_nxt = mrw_pkg::ST_IDLE;
          endcase
        end else bit_nxt = bit_r - BW'(1);
      end
      mrw_pkg::ST_DONE: st_nxt = mrw_pkg::ST_IDLE;
      default: st_nxt = mrw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mrw_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    n_r <= n_nxt; b_r <= b_nxt; e_r <= e_nxt; x_r <= x_nxt; acc_r <= acc_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; s_r <= s_nxt; bit_r <= bit_nxt; use_r <= use_nxt;
    pass_r <= pass_nxt; res_r <= res_nxt;
  end
endmodule

// ===== hw/rtl/miller_rabin_witness_round_unit.sv =====
// Miller-Rabin witness round unit: one base test of a 64-bit candidate per word.
// Small and even candidates are settled by the front classifier. An odd candidate first
// has n-1 stripped into d * 2^s in the front, one trailing zero at a time, then the
// back reduces the base and works through the modular products on one bit-serial
// multiplier: a squaring for every bit of d, a multiply for every set bit of d and
// s-1 final squarings. A two-word queue decouples the front from the back
// engine, and the verdict waits in an output register while the next word is
// classified. Depends on mrw_pkg and mrw_if.
`timescale 1ns / 1ps
module miller_rabin_witness_round_unit (
  input logic clk,
  input logic rst_n,
  mrw_if.sink   in_ch,
  mrw_if.source out_ch
);
  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  mrw_pkg::job_t fq_data, qb_data;

  // classify and split the candidate
  mrw_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_candidate(in_ch.data.candidate), .in_witness_base(in_ch.data.witness_base),
    .job_valid(fq_valid), .job_ready(fq_ready), .job_data(fq_data)
  );

  // hold jobs while the back engine is busy
  mrw_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  // modular exponentiation and squaring chain
  mrw_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(qb_valid), .job_ready(qb_ready), .job_data(qb_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_probably_prime(out_ch.data.probably_prime)
  );
endmodule

// ===== hw/rtl/mrw_checker.sv =====
// Port-level checker for the witness round unit, bound to the top level.
// Depends on the top level's channel interfaces.
`timescale 1ns / 1ps
module mrw_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_probably_prime,
  input logic in_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probably_prime))
    else $error("result word dropped or changed while stalled");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");
endmodule

bind miller_rabin_witness_round_unit mrw_checker u_mrw_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_probably_prime(out_ch.data.probably_prime),
  .in_ready(in_ch.ready)
);

// ===== tb/miller_rabin_witness_round_unit_test.sv =====
// Self-checking test of the Miller-Rabin witness round unit: directed and random
// candidate/base words, verdicts predicted with exact 128-bit modular products.
// Depends on mrw_pkg, mrw_if and the unit itself.
`timescale 1ns / 1ps
module miller_rabin_witness_round_unit_test;
  localparam int NW = mrw_pkg::NUM_WIDTH;

  typedef struct {
    mrw_pkg::in_word_t word;
    bit                wait_drain;  // offer only once every verdict is back
  } pending_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mrw_if #(.payload_t(mrw_pkg::in_word_t))  in_ch (.clk(clk));
  mrw_if #(.payload_t(mrw_pkg::out_word_t)) out_ch (.clk(clk));

  miller_rabin_witness_round_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  pending_word_t pending_words[$];
  bit            verdict_queue[$];
  int            fail_count = 0;
  int            verdicts_seen = 0;
  bit            stim_done = 1'b0;

  // Exact (a * b) mod n through a double-width product.
  function automatic mrw_pkg::num_t mul_mod_exact(mrw_pkg::num_t a, mrw_pkg::num_t b,
                                                  mrw_pkg::num_t n);
    logic [2*NW-1:0] prod;
    prod = {{NW{1'b0}}, a} * {{NW{1'b0}}, b};
    return mrw_pkg::num_t'(prod % {{NW{1'b0}}, n});
  endfunction

  // Verdict of one witness round for candidate n and base b.
  function automatic bit witness_verdict(mrw_pkg::num_t n, mrw_pkg::num_t b);
    mrw_pkg::num_t d, x, e, acc, nm1;
    int            s;
    bit            pass;
    if (n == 0 || n == 1) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (!n[0]) return 1'b0;
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    acc = b % n;
    x = 1;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mul_mod_exact(x, acc, n);
      acc = mul_mod_exact(acc, acc, n);
      e = e >> 1;
    end
    pass = (x == 1) || (x == nm1);
    for (int j = 1; j < s; j++) begin
      x = mul_mod_exact(x, x, n);
      if (x == nm1) pass = 1'b1;
    end
    return pass;
  endfunction

  // Driver: offer queued words, draw a gap after each accepted word.
  int  send_gap = 0;
  bit  send_gaps_on = 1'b1;
  int  sent_count = 0;
  always @(posedge clk) begin
    bit next_valid;
    next_valid = in_ch.valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_queue.push_back(witness_verdict(pending_words[0].word.candidate,
                                                pending_words[0].word.witness_base));
        void'(pending_words.pop_front());
        sent_count++;
        // alternate stretches with and without idling
        if (sent_count % 16 == 0) send_gaps_on = ~send_gaps_on;
        send_gap = send_gaps_on ? $urandom_range(0, 7) : 0;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].wait_drain || verdict_queue.size() == 0)) begin
          next_valid = 1'b1;
          in_ch.data <= pending_words[0].word;
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Monitor: check each verdict, stall at random and once for a long stretch.
  int  recv_gap = 0;
  int  long_hold = 0;
  bit  long_hold_done = 1'b0;
  bit  recv_gaps_on = 1'b1;
  always @(posedge clk) begin
    bit expected_verdict;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_seen++;
        if (verdict_queue.size() == 0) begin
          $error("probably_prime: no verdict expected, got %0b",
                 out_ch.data.probably_prime);
          fail_count++;
        end else begin
          expected_verdict = verdict_queue.pop_front();
          if (out_ch.data.probably_prime !== expected_verdict) begin
            $error("probably_prime: expected %0b, actual %0b", expected_verdict,
                   out_ch.data.probably_prime);
            fail_count++;
          end
        end
        if (verdicts_seen % 20 == 0) recv_gaps_on = ~recv_gaps_on;
        recv_gap = recv_gaps_on ? $urandom_range(0, 7) : 0;
        // hold off long once so the front part and its queue back up
        if (verdicts_seen == 30 && !long_hold_done) begin
          long_hold = 600;
          long_hold_done = 1'b1;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(mrw_pkg::num_t cand, mrw_pkg::num_t base, bit drain = 1'b0);
    pending_word_t p;
    p.word.candidate    = cand;
    p.word.witness_base = base;
    p.wait_drain        = drain;
    pending_words.push_back(p);
  endtask

  function automatic mrw_pkg::num_t rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  localparam mrw_pkg::num_t PRIME_TOP = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64 - 59
  localparam mrw_pkg::num_t PRIME_M61 = 64'h1FFF_FFFF_FFFF_FFFF;

  initial begin
    mrw_pkg::num_t cand;
    int            pick;
    mrw_pkg::num_t small_primes[8];
    small_primes = '{5, 7, 13, 97, 65521, 7919, 40961, 65537};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // small and even candidates
    queue_word(0, rand_wide());
    queue_word(1, '1);
    queue_word(2, 0);
    queue_word(3, '1);
    queue_word(4, 3);
    queue_word(64'hFFFF_FFFF_FFFF_FFFE, 3);
    // strong pseudoprime to base 2, caught by base 3; Carmichael number
    queue_word(2047, 2);
    queue_word(2047, 3);
    queue_word(561, 2);
    // bases congruent to 0, 1 and n-1, and bases at or above n
    queue_word(97, 97);
    queue_word(97, 98);
    queue_word(97, 96, 1'b1);
    queue_word(PRIME_TOP, PRIME_TOP);
    queue_word(PRIME_TOP, '1);
    // full-width candidates
    queue_word(PRIME_TOP, 2);
    queue_word(PRIME_M61, 64'h8000_0000_0000_0001);
    queue_word('1, 2);
    queue_word(64'h8000_0000_0000_0001, 3);

    for (int i = 0; i < 95; i++) begin
      pick = $urandom_range(0, 99);
      if (i >= 25 && i < 35) begin
        // cheap words while the receiver is expected to be holding off
        cand = $urandom_range(0, 3) == 0 ? mrw_pkg::num_t'($urandom_range(0, 3))
                                         : rand_wide() & ~64'd1;
      end else if (pick < 55) begin
        cand = mrw_pkg::num_t'($urandom_range(5, 65535)) | 64'd1;
      end else if (pick < 75) begin
        cand = small_primes[$urandom_range(0, 7)];
      end else if (pick < 85) begin
        cand = rand_wide() & ~64'd1;
      end else if (pick < 90) begin
        cand = mrw_pkg::num_t'($urandom_range(0, 3));
      end else begin
        cand = rand_wide() | 64'd1;
      end
      queue_word(cand, rand_wide(), i == 60);
    end
    stim_done = 1'b1;

    wait (pending_words.size() == 0 && verdict_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && verdict_queue.size() == 0) begin
      $display("miller_rabin_witness_round_unit_test OK");
    end else begin
      $display("miller_rabin_witness_round_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("miller_rabin_witness_round_unit_test NOT OK");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/mrw_pkg.sv
hw/rtl/mrw_if.sv
hw/rtl/mrw_front.sv
hw/rtl/mrw_queue.sv
hw/rtl/mrw_back.sv
hw/rtl/miller_rabin_witness_round_unit.sv
hw/rtl/mrw_checker.sv
tb/miller_rabin_witness_round_unit_test.sv
